// ===== hw/rtl/masked_plane_fit_offset_correction_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the plane fit offset correction block
// Simulation builds get concurrent assertions, synthesis builds get nothing.
// ----------------------------------------------------------------------------
`ifndef MASKED_PLANE_FIT_OFFSET_CORRECTION_ASSERT_SVH
`define MASKED_PLANE_FIT_OFFSET_CORRECTION_ASSERT_SVH
`ifndef SYNTHESIS
`define MPFOC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define MPFOC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define MPFOC_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define MPFOC_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== hw/rtl/mpfoc_pkg.sv =====
// ----------------------------------------------------------------------------
// mpfoc_pkg
// Types, widths, codes and matrix helpers of the plane fit offset correction.
// ----------------------------------------------------------------------------
`default_nettype none

package mpfoc_pkg;

	localparam int MAX_SLICES = 64;
	localparam int COMPONENTS = 3;
	localparam int IMAGE_DIM  = 256;
	localparam int TABLE_SIZE = MAX_SLICES * COMPONENTS;
	localparam int IDX_W      = $clog2(TABLE_SIZE);

	localparam int SLICE_W  = 6;
	localparam int COMP_W   = 2;
	localparam int FRAME_W  = 6;
	localparam int POS_W    = 8;
	localparam int TISSUE_W = 16;
	localparam int VEL_W    = 16;
	localparam int COEF_W   = 32;
	localparam int STATUS_W = 2;
	localparam int FRAC_W   = 16;

	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_REF_FRAME = 1'b1;

	localparam logic KIND_FIT     = 1'b0;
	localparam logic KIND_CORRECT = 1'b1;

	localparam logic [STATUS_W-1:0] STATUS_OK         = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_SINGULAR   = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_NOT_FITTED = 2'd2;

	localparam int SX_W  = 24;
	localparam int SXX_W = 34;
	localparam int N_W   = 17;
	localparam int SXV_W = 48;
	localparam int SV_W  = 40;

	// matrix element, its magnitude, determinant and dividend widths
	localparam int ELEM_W = 49;
	localparam int MAG_W  = 48;
	localparam int DET_W  = 120;
	localparam int DIV_W  = DET_W + FRAC_W;
	localparam int QUO_W  = COEF_W + 1;

	typedef struct packed {
		logic                       is_correct;
		logic [SLICE_W-1:0]         slice;
		logic [COMP_W-1:0]          component;
		logic [POS_W-1:0]           pos_x;
		logic [POS_W-1:0]           pos_y;
		logic signed [VEL_W-1:0]    velocity;
		logic                       last;
		logic                       use_px;
		logic                       in_range;
		logic [IDX_W-1:0]           idx;
	} item_t;

	typedef struct packed {
		logic [SX_W-1:0]  sx;
		logic [SX_W-1:0]  sy;
		logic [SXX_W-1:0] sxx;
		logic [SXX_W-1:0] syy;
		logic [SXX_W-1:0] sxy;
		logic [N_W-1:0]   n;
		logic [SXV_W-1:0] sxv;
		logic [SXV_W-1:0] syv;
		logic [SV_W-1:0]  sv;
	} sums_t;

	typedef struct packed {
		logic                     singular;
		logic [COEF_W-1:0]        cx;
		logic [COEF_W-1:0]        cy;
		logic [COEF_W-1:0]        c0;
	} solve_res_t;

	typedef struct packed {
		logic                     result_kind;
		logic [STATUS_W-1:0]      status;
		logic [COEF_W-1:0]        coef_x;
		logic [COEF_W-1:0]        coef_y;
		logic [COEF_W-1:0]        coef_offset;
		logic [VEL_W-1:0]         corrected_velocity;
	} res_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_START,
		BK_WAIT,
		BK_RD,
		BK_PLANE,
		BK_ROUND
	} back_state_t;

	typedef enum logic [2:0] {
		SV_IDLE,
		SV_LOAD,
		SV_MUL1,
		SV_MUL2,
		SV_CHECK,
		SV_DLOAD,
		SV_DIV,
		SV_DFIN
	} solver_state_t;

	// column picked in each row by one of the six permutation terms of a 3x3 det
	function automatic logic [1:0] term_col(input logic [2:0] term, input logic [1:0] row);
		logic [5:0] cols;
		unique case (term)
			3'd0:    cols = {2'd2, 2'd1, 2'd0};
			3'd1:    cols = {2'd1, 2'd2, 2'd0};
			3'd2:    cols = {2'd2, 2'd0, 2'd1};
			3'd3:    cols = {2'd0, 2'd2, 2'd1};
			3'd4:    cols = {2'd1, 2'd0, 2'd2};
			3'd5:    cols = {2'd0, 2'd1, 2'd2};
			default: cols = {2'd2, 2'd1, 2'd0};
		endcase
		unique case (row)
			2'd0:    return cols[1:0];
			2'd1:    return cols[3:2];
			default: return cols[5:4];
		endcase
	endfunction

	function automatic logic term_neg(input logic [2:0] term);
		return (term == 3'd1) || (term == 3'd2) || (term == 3'd5);
	endfunction

	// element of the normal matrix; det_sel 1..3 swaps column det_sel-1 for b
	function automatic logic signed [ELEM_W-1:0] elem(input sums_t s,
			input logic [1:0] det_sel, input logic [1:0] row, input logic [1:0] col);
		logic signed [ELEM_W-1:0] a;
		logic signed [ELEM_W-1:0] b;
		unique case (row)
			2'd0:    b = ELEM_W'(signed'(s.sxv));
			2'd1:    b = ELEM_W'(signed'(s.syv));
			default: b = ELEM_W'(signed'(s.sv));
		endcase
		unique case ({row, col})
			4'b0000: a = signed'(ELEM_W'(s.sxx));
			4'b0001: a = signed'(ELEM_W'(s.sxy));
			4'b0010: a = signed'(ELEM_W'(s.sx));
			4'b0100: a = signed'(ELEM_W'(s.sxy));
			4'b0101: a = signed'(ELEM_W'(s.syy));
			4'b0110: a = signed'(ELEM_W'(s.sy));
			4'b1000: a = signed'(ELEM_W'(s.sx));
			4'b1001: a = signed'(ELEM_W'(s.sy));
			default: a = signed'(ELEM_W'(s.n));
		endcase
		if (det_sel != 2'd0 && col == 2'(det_sel - 2'd1)) begin
			return b;
		end
		return a;
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/mpfoc_sample_if.sv =====
// ----------------------------------------------------------------------------
// mpfoc_sample_if
// Input channel: one pixel transaction with valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface mpfoc_sample_if;
	import mpfoc_pkg::*;

	logic                    valid;
	logic                    ready;
	logic                    req_type;
	logic [SLICE_W-1:0]      slice;
	logic [COMP_W-1:0]       component;
	logic [FRAME_W-1:0]      frame;
	logic [POS_W-1:0]        pos_x;
	logic [POS_W-1:0]        pos_y;
	logic [TISSUE_W-1:0]     tissue_level;
	logic signed [VEL_W-1:0] velocity;
	logic                    last;

	modport source (output valid, req_type, slice, component, frame, pos_x, pos_y,
		tissue_level, velocity, last, input ready);
	modport sink (input valid, req_type, slice, component, frame, pos_x, pos_y,
		tissue_level, velocity, last, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/mpfoc_result_if.sv =====
// ----------------------------------------------------------------------------
// mpfoc_result_if
// Output channel: one plane or corrected velocity transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface mpfoc_result_if;
	import mpfoc_pkg::*;

	logic                    valid;
	logic                    ready;
	logic                    result_kind;
	logic [STATUS_W-1:0]     status;
	logic signed [COEF_W-1:0] coef_x;
	logic signed [COEF_W-1:0] coef_y;
	logic signed [COEF_W-1:0] coef_offset;
	logic signed [VEL_W-1:0] corrected_velocity;

	modport source (output valid, result_kind, status, coef_x, coef_y, coef_offset,
		corrected_velocity, input ready);
	modport sink (input valid, result_kind, status, coef_x, coef_y, coef_offset,
		corrected_velocity, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/masked_plane_fit_offset_correction.sv =====
// ----------------------------------------------------------------------------
// masked_plane_fit_offset_correction
// Least-squares background plane fit per slice and component, and correction.
// ----------------------------------------------------------------------------
// Usage:
//   sample carries fit and correct transactions (valid/ready). result carries
//   one plane transaction for each fit pixel with last set, and one corrected
//   velocity for each correct transaction; other fit pixels give none.
//   cfg_wr_en/cfg_index/cfg_data write the tissue threshold (0) and the
//   reference frame (1); write them only while the block is idle.
//   Fit pixels that are not last run at one per cycle through the sum update
//   while the back end is idle. A last pixel starts the solve: four 3x3
//   determinants of six terms, each term two bit-serial 48-step products,
//   then three 136-step restoring divisions, before the plane is loaded into
//   the output register. A correct transaction goes through the back end as
//   pop, table read, plane product and round, one item at a time.
//   A two-entry queue and the output register let sample keep accepting while
//   result is stalled; once both fill, sample.ready drops.
//   Reset clears configuration, sums and the fitted flag; the plane table is
//   not cleared, and the fitted flag is one flag for the whole table.
// ----------------------------------------------------------------------------
`default_nettype none

module masked_plane_fit_offset_correction (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_wr_en,
	input  wire logic [mpfoc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [mpfoc_pkg::CFG_DATA_W-1:0] cfg_data,
	mpfoc_sample_if.sink                         sample,
	mpfoc_result_if.source                       result
);
	import mpfoc_pkg::*;

	logic  push_valid, push_ready;
	item_t push_item;
	logic  pop_valid, pop_ready;
	item_t pop_item;

	mpfoc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.sample     (sample),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item)
	);

	mpfoc_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_item   (pop_item)
	);

	mpfoc_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (pop_valid),
		.q_ready (pop_ready),
		.q_item  (pop_item),
		.result  (result)
	);

endmodule

`default_nettype wire

// ===== hw/rtl/mpfoc_front.sv =====
// ----------------------------------------------------------------------------
// mpfoc_front
// Holds configuration, classifies each accepted pixel and pushes it on.
// ----------------------------------------------------------------------------
`default_nettype none

module mpfoc_front (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_wr_en,
	input  wire logic [mpfoc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [mpfoc_pkg::CFG_DATA_W-1:0] cfg_data,
	mpfoc_sample_if.sink                         sample,
	output logic                                 push_valid,
	input  wire logic                            push_ready,
	output mpfoc_pkg::item_t                     push_item
);
	import mpfoc_pkg::*;

	logic [TISSUE_W-1:0] threshold_q;
	logic [FRAME_W-1:0]  ref_frame_q;
	logic                in_range;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= '0;
			ref_frame_q <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				CFG_THRESHOLD: threshold_q <= cfg_data[TISSUE_W-1:0];
				default:       ref_frame_q <= cfg_data[FRAME_W-1:0];
			endcase
		end
	end

	assign in_range = (32'(sample.slice) < MAX_SLICES) && (32'(sample.component) < COMPONENTS);

	always_comb begin
		push_item.is_correct = (sample.req_type == KIND_CORRECT);
		push_item.slice      = sample.slice;
		push_item.component  = sample.component;
		push_item.pos_x      = sample.pos_x;
		push_item.pos_y      = sample.pos_y;
		push_item.velocity   = sample.velocity;
		push_item.last       = sample.last;
		push_item.in_range   = in_range;
		push_item.use_px     = (sample.frame == ref_frame_q)
			&& (sample.tissue_level <= threshold_q)
			&& (32'(sample.pos_x) < IMAGE_DIM) && (32'(sample.pos_y) < IMAGE_DIM);
		push_item.idx = in_range
			? IDX_W'(32'(sample.slice) * COMPONENTS + 32'(sample.component)) : '0;
	end

	assign push_valid   = sample.valid;
	assign sample.ready = push_ready;

endmodule

`default_nettype wire

// ===== hw/rtl/mpfoc_queue.sv =====
// ----------------------------------------------------------------------------
// mpfoc_queue
// Two-entry queue between the classifying front and the executing back.
// ----------------------------------------------------------------------------
`default_nettype none

module mpfoc_queue (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         push_valid,
	output logic              push_ready,
	input  mpfoc_pkg::item_t  push_item,
	output logic              pop_valid,
	input  wire logic         pop_ready,
	output mpfoc_pkg::item_t  pop_item
);
	import mpfoc_pkg::*;

	item_t       slot_q [2];
	logic        wr_ptr_q;
	logic        rd_ptr_q;
	logic [1:0]  count_q;
	logic        do_push;
	logic        do_pop;

	assign push_ready = (count_q != 2'd2);
	assign pop_valid  = (count_q != 2'd0);
	assign pop_item   = slot_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			count_q <= 2'(count_q + {1'b0, do_push} - {1'b0, do_pop});
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/mpfoc_solver.sv =====
// ----------------------------------------------------------------------------
// mpfoc_solver
// Cramer solve of the 3x3 normal equations: bit-serial products for the four
// determinants, then a restoring divider for the three Q16.16 coefficients.
// ----------------------------------------------------------------------------
`default_nettype none

module mpfoc_solver (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  mpfoc_pkg::sums_t       sums,
	output logic                   busy,
	output mpfoc_pkg::solve_res_t  res
);
	import mpfoc_pkg::*;

	localparam int BIT_CNT_W = $clog2(MAG_W);
	localparam int DIV_CNT_W = $clog2(DIV_W);
	localparam logic [BIT_CNT_W-1:0] BIT_LAST = BIT_CNT_W'(MAG_W - 1);
	localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_W - 1);

	solver_state_t          state_q, state_d;
	logic [1:0]             det_sel_q;
	logic [2:0]             term_q;
	logic [BIT_CNT_W-1:0]   bit_cnt_q;
	logic [DIV_CNT_W-1:0]   div_cnt_q;
	logic [1:0]             coef_idx_q;
	logic [DET_W-1:0]       det_q [4];
	logic [DET_W-1:0]       det_acc_q;
	logic [DET_W-1:0]       mcand_q;
	logic [DET_W-1:0]       prod_q;
	logic [MAG_W-1:0]       mplier_q;
	logic [MAG_W-1:0]       r_mag_q;
	logic                   sign_q;
	logic [DIV_W-1:0]       numer_q;
	logic [DET_W-1:0]       den_q;
	logic [DET_W-1:0]       rem_q;
	logic [QUO_W-1:0]       quo_q;
	logic                   ovf_q;
	logic                   neg_q;
	logic                   singular_q;
	logic [COEF_W-1:0]      coef_q [3];

	logic signed [ELEM_W-1:0] e_p, e_q, e_r;
	logic [MAG_W-1:0]       m_p, m_q, m_r;
	logic [DET_W-1:0]       prod_next;
	logic [DET_W-1:0]       det_sum;
	logic [DET_W-1:0]       num_sel;
	logic [DET_W:0]         rs;
	logic [DET_W+1:0]       trial;
	logic                   ge;
	logic                   round_up;
	logic [QUO_W:0]         mag_r;
	logic [QUO_W:0]         lim;
	logic [QUO_W:0]         mag_f;

	function automatic logic [MAG_W-1:0] mag_of(input logic signed [ELEM_W-1:0] e);
		return e[ELEM_W-1] ? MAG_W'(-e) : MAG_W'(e);
	endfunction

	always_comb begin
		e_p = elem(sums, det_sel_q, 2'd0, term_col(term_q, 2'd0));
		e_q = elem(sums, det_sel_q, 2'd1, term_col(term_q, 2'd1));
		e_r = elem(sums, det_sel_q, 2'd2, term_col(term_q, 2'd2));
		m_p = mag_of(e_p);
		m_q = mag_of(e_q);
		m_r = mag_of(e_r);
		prod_next = (prod_q << 1) + (mplier_q[MAG_W-1] ? mcand_q : '0);
		det_sum   = det_acc_q + (sign_q ? -prod_next : prod_next);
		num_sel   = det_q[2'(coef_idx_q + 2'd1)];
		rs        = {rem_q, numer_q[DIV_W-1]};
		trial     = {1'b0, rs} - {2'b00, den_q};
		ge        = !trial[DET_W+1];
		round_up  = ({rem_q, 1'b0} >= {1'b0, den_q});
		mag_r     = (QUO_W+1)'(quo_q) + (QUO_W+1)'(round_up);
		lim       = neg_q ? (QUO_W+1)'(1) << (COEF_W - 1)
			: ((QUO_W+1)'(1) << (COEF_W - 1)) - (QUO_W+1)'(1);
		mag_f     = (ovf_q || mag_r > lim) ? lim : mag_r;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			SV_IDLE:  if (start) state_d = SV_LOAD;
			SV_LOAD:  state_d = SV_MUL1;
			SV_MUL1:  if (bit_cnt_q == BIT_LAST) state_d = SV_MUL2;
			SV_MUL2: begin
				if (bit_cnt_q == BIT_LAST) begin
					state_d = (term_q == 3'd5 && det_sel_q == 2'd3) ? SV_CHECK : SV_LOAD;
				end
			end
			SV_CHECK: state_d = (det_q[0] == '0) ? SV_IDLE : SV_DLOAD;
			SV_DLOAD: state_d = SV_DIV;
			SV_DIV:   if (div_cnt_q == DIV_LAST) state_d = SV_DFIN;
			SV_DFIN:  state_d = (coef_idx_q == 2'd2) ? SV_IDLE : SV_DLOAD;
			default:  state_d = SV_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SV_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			SV_IDLE: begin
				det_sel_q <= 2'd0;
				term_q    <= 3'd0;
				det_acc_q <= '0;
			end
			SV_LOAD: begin
				sign_q    <= e_p[ELEM_W-1] ^ e_q[ELEM_W-1] ^ e_r[ELEM_W-1] ^ term_neg(term_q);
				mcand_q   <= DET_W'(m_p);
				mplier_q  <= m_q;
				r_mag_q   <= m_r;
				prod_q    <= '0;
				bit_cnt_q <= '0;
			end
			SV_MUL1: begin
				if (bit_cnt_q == BIT_LAST) begin
					// second pass multiplies the pair product by the third factor
					bit_cnt_q <= '0;
					mcand_q   <= prod_next;
					prod_q    <= '0;
					mplier_q  <= r_mag_q;
				end else begin
					bit_cnt_q <= BIT_CNT_W'(bit_cnt_q + 1'b1);
					prod_q    <= prod_next;
					mplier_q  <= mplier_q << 1;
				end
			end
			SV_MUL2: begin
				bit_cnt_q <= BIT_CNT_W'(bit_cnt_q + 1'b1);
				prod_q    <= prod_next;
				mplier_q  <= mplier_q << 1;
				if (bit_cnt_q == BIT_LAST) begin
					if (term_q == 3'd5) begin
						det_q[det_sel_q] <= det_sum;
						det_acc_q        <= '0;
						term_q           <= 3'd0;
						det_sel_q        <= 2'(det_sel_q + 2'd1);
					end else begin
						det_acc_q <= det_sum;
						term_q    <= 3'(term_q + 3'd1);
					end
				end
			end
			SV_CHECK: begin
				coef_idx_q <= 2'd0;
				singular_q <= (det_q[0] == '0);
				if (det_q[0] == '0) begin
					coef_q[0] <= '0;
					coef_q[1] <= '0;
					coef_q[2] <= '0;
				end
			end
			SV_DLOAD: begin
				neg_q     <= num_sel[DET_W-1] ^ det_q[0][DET_W-1];
				numer_q   <= {(num_sel[DET_W-1] ? -num_sel : num_sel), FRAC_W'(0)};
				den_q     <= det_q[0][DET_W-1] ? -det_q[0] : det_q[0];
				rem_q     <= '0;
				quo_q     <= '0;
				ovf_q     <= 1'b0;
				div_cnt_q <= '0;
			end
			SV_DIV: begin
				div_cnt_q <= DIV_CNT_W'(div_cnt_q + 1'b1);
				numer_q   <= numer_q << 1;
				rem_q     <= ge ? trial[DET_W-1:0] : rs[DET_W-1:0];
				quo_q     <= {quo_q[QUO_W-2:0], ge};
				ovf_q     <= ovf_q | quo_q[QUO_W-1];
			end
			SV_DFIN: begin
				coef_q[coef_idx_q] <= COEF_W'(neg_q ? -mag_f : mag_f);
				coef_idx_q         <= 2'(coef_idx_q + 2'd1);
			end
			default: ;
		endcase
	end

	assign busy         = (state_q != SV_IDLE);
	assign res.singular = singular_q;
	assign res.cx       = coef_q[0];
	assign res.cy       = coef_q[1];
	assign res.c0       = coef_q[2];

endmodule

`default_nettype wire

// ===== hw/rtl/mpfoc_back.sv =====
// ----------------------------------------------------------------------------
// mpfoc_back
// Executes queued items: accumulates fit sums, runs the solve, keeps the plane
// table and corrects velocities; owns the output register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "masked_plane_fit_offset_correction_assert.svh"

module mpfoc_back (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         q_valid,
	output logic              q_ready,
	input  mpfoc_pkg::item_t  q_item,
	mpfoc_result_if.source    result
);
	import mpfoc_pkg::*;

	localparam int PLANE_W = COEF_W + POS_W + 3;
	localparam int DIFF_W  = PLANE_W + 1;
	localparam int ROW_W   = 3 * COEF_W;

	back_state_t state_q, state_d;
	item_t       cur_q;
	logic        fitted_q;
	logic        res_valid_q;
	res_t        res_q;
	res_t        res_d;

	logic [SX_W-1:0]  sum_x_q, sum_y_q;
	logic [SXX_W-1:0] sum_xx_q, sum_yy_q, sum_xy_q;
	logic [N_W-1:0]   count_q;
	logic [SXV_W-1:0] sum_xv_q, sum_yv_q;
	logic [SV_W-1:0]  sum_v_q;

	logic [ROW_W-1:0] mem [TABLE_SIZE];
	logic [ROW_W-1:0] rd_q;
	logic signed [PLANE_W-1:0] plane_q;

	logic        q_pop;
	logic        acc_en;
	logic        out_free;
	logic        fit_done;
	logic        mem_we;
	logic        out_load;
	logic        slv_start;
	logic        slv_busy;
	sums_t       sums;
	solve_res_t  slv_res;

	logic signed [COEF_W+POS_W:0]     px, py;
	logic signed [PLANE_W-1:0]        plane_d;
	logic signed [DIFF_W-1:0]         diff;
	logic [DIFF_W-1:0]                mag;
	logic [DIFF_W-1:0]                rnd;
	logic signed [VEL_W-1:0]          cv;
	logic signed [POS_W+VEL_W:0]      xv, yv;

	assign sums = '{sx: sum_x_q, sy: sum_y_q, sxx: sum_xx_q, syy: sum_yy_q, sxy: sum_xy_q,
		n: count_q, sxv: sum_xv_q, syv: sum_yv_q, sv: sum_v_q};

	mpfoc_solver u_solver (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (slv_start),
		.sums   (sums),
		.busy   (slv_busy),
		.res    (slv_res)
	);

	assign out_free = !res_valid_q || result.ready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_IDLE: begin
				if (q_valid) begin
					if (q_item.is_correct) begin
						state_d = BK_RD;
					end else if (q_item.last) begin
						state_d = BK_START;
					end
				end
			end
			BK_START: state_d = BK_WAIT;
			BK_WAIT:  if (!slv_busy && out_free) state_d = BK_IDLE;
			BK_RD:    state_d = BK_PLANE;
			BK_PLANE: state_d = BK_ROUND;
			BK_ROUND: if (out_free) state_d = BK_IDLE;
			default:  state_d = BK_IDLE;
		endcase
	end

	always_comb begin
		q_ready   = (state_q == BK_IDLE);
		q_pop     = q_ready && q_valid;
		acc_en    = q_pop && !q_item.is_correct && q_item.use_px;
		slv_start = (state_q == BK_START);
		fit_done  = (state_q == BK_WAIT) && !slv_busy && out_free;
		mem_we    = fit_done && cur_q.in_range;
		out_load  = fit_done || ((state_q == BK_ROUND) && out_free);
	end

	// correction datapath
	always_comb begin
		px      = $signed(rd_q[COEF_W-1:0]) * $signed({1'b0, cur_q.pos_x});
		py      = $signed(rd_q[2*COEF_W-1:COEF_W]) * $signed({1'b0, cur_q.pos_y});
		plane_d = PLANE_W'(px) + PLANE_W'(py) + PLANE_W'($signed(rd_q[ROW_W-1:2*COEF_W]));
		diff    = DIFF_W'($signed({cur_q.velocity, FRAC_W'(0)})) - DIFF_W'(plane_q);
		mag     = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
		rnd     = (mag + (DIFF_W'(1) << (FRAC_W - 1))) >> FRAC_W;
		if (diff[DIFF_W-1]) begin
			cv = (rnd >= (DIFF_W'(1) << (VEL_W - 1))) ? {1'b1, (VEL_W-1)'(0)}
				: VEL_W'(-rnd);
		end else begin
			cv = (rnd > ((DIFF_W'(1) << (VEL_W - 1)) - DIFF_W'(1))) ? {1'b0, {(VEL_W-1){1'b1}}}
				: VEL_W'(rnd);
		end
		xv = $signed({1'b0, q_item.pos_x}) * q_item.velocity;
		yv = $signed({1'b0, q_item.pos_y}) * q_item.velocity;
	end

	always_comb begin
		res_d.corrected_velocity = '0;
		if (state_q == BK_WAIT) begin
			res_d.result_kind = KIND_FIT;
			res_d.status      = slv_res.singular ? STATUS_SINGULAR : STATUS_OK;
			res_d.coef_x      = slv_res.cx;
			res_d.coef_y      = slv_res.cy;
			res_d.coef_offset = slv_res.c0;
		end else if (!fitted_q || !cur_q.in_range) begin
			res_d.result_kind        = KIND_CORRECT;
			res_d.status             = STATUS_NOT_FITTED;
			res_d.coef_x             = '0;
			res_d.coef_y             = '0;
			res_d.coef_offset        = '0;
			res_d.corrected_velocity = cur_q.velocity;
		end else begin
			res_d.result_kind        = KIND_CORRECT;
			res_d.status             = STATUS_OK;
			res_d.coef_x             = rd_q[COEF_W-1:0];
			res_d.coef_y             = rd_q[2*COEF_W-1:COEF_W];
			res_d.coef_offset        = rd_q[ROW_W-1:2*COEF_W];
			res_d.corrected_velocity = cv;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[cur_q.idx] <= {slv_res.c0, slv_res.cy, slv_res.cx};
		end
		rd_q <= mem[cur_q.idx];
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_q <= q_item;
		end
		if (state_q == BK_PLANE) begin
			plane_q <= plane_d;
		end
		if (out_load) begin
			res_q <= res_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			fitted_q    <= 1'b0;
			res_valid_q <= 1'b0;
			sum_x_q     <= '0;
			sum_y_q     <= '0;
			sum_xx_q    <= '0;
			sum_yy_q    <= '0;
			sum_xy_q    <= '0;
			count_q     <= '0;
			sum_xv_q    <= '0;
			sum_yv_q    <= '0;
			sum_v_q     <= '0;
		end else begin
			state_q <= state_d;
			if (mem_we) begin
				fitted_q <= 1'b1;
			end
			if (out_load) begin
				res_valid_q <= 1'b1;
			end else if (result.ready) begin
				res_valid_q <= 1'b0;
			end
			if (fit_done) begin
				// clear for the next slice
				sum_x_q  <= '0;
				sum_y_q  <= '0;
				sum_xx_q <= '0;
				sum_yy_q <= '0;
				sum_xy_q <= '0;
				count_q  <= '0;
				sum_xv_q <= '0;
				sum_yv_q <= '0;
				sum_v_q  <= '0;
			end else if (acc_en) begin
				sum_x_q  <= sum_x_q + SX_W'(q_item.pos_x);
				sum_y_q  <= sum_y_q + SX_W'(q_item.pos_y);
				sum_xx_q <= sum_xx_q + SXX_W'({{POS_W{1'b0}}, q_item.pos_x}
					* {{POS_W{1'b0}}, q_item.pos_x});
				sum_yy_q <= sum_yy_q + SXX_W'({{POS_W{1'b0}}, q_item.pos_y}
					* {{POS_W{1'b0}}, q_item.pos_y});
				sum_xy_q <= sum_xy_q + SXX_W'({{POS_W{1'b0}}, q_item.pos_x}
					* {{POS_W{1'b0}}, q_item.pos_y});
				count_q  <= N_W'(count_q + 1'b1);
				sum_xv_q <= sum_xv_q + SXV_W'(xv);
				sum_yv_q <= sum_yv_q + SXV_W'(yv);
				sum_v_q  <= sum_v_q + SV_W'(q_item.velocity);
			end
		end
	end

	assign result.valid              = res_valid_q;
	assign result.result_kind        = res_q.result_kind;
	assign result.status             = res_q.status;
	assign result.coef_x             = res_q.coef_x;
	assign result.coef_y             = res_q.coef_y;
	assign result.coef_offset        = res_q.coef_offset;
	assign result.corrected_velocity = res_q.corrected_velocity;

	`MPFOC_ASSERT_IMP(a_pop_only_idle, clk, arst_n, q_pop, state_q == BK_IDLE)
	`MPFOC_ASSERT_IMP(a_load_when_free, clk, arst_n, out_load, !res_valid_q || result.ready)
	`MPFOC_ASSERT_NXT(a_solver_runs, clk, arst_n, state_q == BK_START, slv_busy)
	`MPFOC_ASSERT_IMP(a_store_fit_only, clk, arst_n, mem_we,
		cur_q.in_range && !cur_q.is_correct && cur_q.last)

endmodule

`default_nettype wire

// ===== tb/mpfoc_checker.sv =====
// ----------------------------------------------------------------------------
// mpfoc_checker
// Watches the sample, result and register ports of the plane fit block, keeps
// its own copy of the sums, plane table and settings, predicts every plane and
// corrected velocity, and compares them in order with what the block returns.
// ----------------------------------------------------------------------------
`default_nettype none

module mpfoc_checker
	import mpfoc_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_wr_en,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	mpfoc_sample_if                    smp,
	mpfoc_result_if                    res,
	output int                         errors,
	output int                         pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef logic signed [191:0] wide_t;

	logic [TISSUE_W-1:0]       threshold;
	logic [FRAME_W-1:0]        ref_frame;
	sums_t                     acc;
	logic signed [COEF_W-1:0]  plane_cx [TABLE_SIZE];
	logic signed [COEF_W-1:0]  plane_cy [TABLE_SIZE];
	logic signed [COEF_W-1:0]  plane_c0 [TABLE_SIZE];
	bit                        any_fitted;
	res_t                      plane_q [$];

	function automatic wide_t det3(input wide_t m [9]);
		return m[0]*m[4]*m[8] - m[0]*m[5]*m[7] - m[1]*m[3]*m[8]
			+ m[1]*m[5]*m[6] + m[2]*m[3]*m[7] - m[2]*m[4]*m[6];
	endfunction

	// rounded Q16.16 quotient, ties away from zero, saturated
	function automatic logic signed [COEF_W-1:0] q16_quotient(input wide_t num, input wide_t den);
		logic [191:0] n;
		logic [191:0] d;
		logic [191:0] q;
		logic [191:0] r;
		logic [63:0]  mag;
		logic [63:0]  lim;
		bit           neg;
		neg = num[191] ^ den[191];
		n = num << 16;
		if (n[191]) begin
			n = -n;
		end
		d = den;
		if (d[191]) begin
			d = -d;
		end
		q = n / d;
		r = n % d;
		if ((r << 1) >= d) begin
			q = q + 1;
		end
		if (q[191:64] != 0) begin
			return neg ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
		end
		mag = q[63:0];
		lim = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
		if (mag > lim) begin
			mag = lim;
		end
		return neg ? -mag[31:0] : mag[31:0];
	endfunction

	function automatic void fit_pixel(input logic [SLICE_W-1:0] sl,
			input logic [COMP_W-1:0] cp, input logic [FRAME_W-1:0] fr,
			input logic [POS_W-1:0] x, input logic [POS_W-1:0] y,
			input logic [TISSUE_W-1:0] ts, input logic signed [VEL_W-1:0] v,
			input logic lst);
		wide_t        a [9];
		wide_t        m [9];
		wide_t        b [3];
		wide_t        d;
		logic signed [COEF_W-1:0] c [3];
		logic [STATUS_W-1:0] st;
		longint       px;
		longint       py;
		bit           in_range;
		int           idx;
		in_range = (sl < MAX_SLICES) && (cp < COMPONENTS);
		idx = sl * COMPONENTS + cp;
		if (fr == ref_frame && ts <= threshold) begin
			px = longint'(x) * longint'(v);
			py = longint'(y) * longint'(v);
			acc.sx  += x;
			acc.sy  += y;
			acc.sxx += x * x;
			acc.syy += y * y;
			acc.sxy += x * y;
			acc.n   += 1;
			acc.sxv += px[SXV_W-1:0];
			acc.syv += py[SXV_W-1:0];
			acc.sv  += SV_W'(v);
		end
		if (!lst) begin
			return;
		end
		a[0] = wide_t'(acc.sxx); a[1] = wide_t'(acc.sxy); a[2] = wide_t'(acc.sx);
		a[3] = wide_t'(acc.sxy); a[4] = wide_t'(acc.syy); a[5] = wide_t'(acc.sy);
		a[6] = wide_t'(acc.sx);  a[7] = wide_t'(acc.sy);  a[8] = wide_t'(acc.n);
		b[0] = wide_t'($signed(acc.sxv));
		b[1] = wide_t'($signed(acc.syv));
		b[2] = wide_t'($signed(acc.sv));
		d = det3(a);
		c = '{0, 0, 0};
		st = STATUS_OK;
		if (d == 0) begin
			st = STATUS_SINGULAR;
		end else begin
			for (int k = 0; k < 3; k++) begin
				m = a;
				for (int i = 0; i < 3; i++) begin
					m[i*3 + k] = b[i];
				end
				c[k] = q16_quotient(det3(m), d);
			end
		end
		if (in_range) begin
			plane_cx[idx] = c[0];
			plane_cy[idx] = c[1];
			plane_c0[idx] = c[2];
			any_fitted = 1;
		end
		acc = '0;
		plane_q.push_back('{KIND_FIT, st, c[0], c[1], c[2], '0});
	endfunction

	function automatic void correct_velocity(input logic [SLICE_W-1:0] sl,
			input logic [COMP_W-1:0] cp, input logic [POS_W-1:0] x,
			input logic [POS_W-1:0] y, input logic signed [VEL_W-1:0] v);
		longint plane;
		longint diff;
		longint mag;
		longint r;
		int     idx;
		idx = sl * COMPONENTS + cp;
		if (!any_fitted || sl >= MAX_SLICES || cp >= COMPONENTS) begin
			plane_q.push_back('{KIND_CORRECT, STATUS_NOT_FITTED, '0, '0, '0, v});
			return;
		end
		plane = longint'(plane_cx[idx]) * longint'(x) + longint'(plane_cy[idx]) * longint'(y)
			+ longint'(plane_c0[idx]);
		diff = longint'(v) * 65536 - plane;
		mag = diff < 0 ? -diff : diff;
		r = (mag + 32768) / 65536;
		if (diff < 0) begin
			r = -r;
		end
		if (r > 32767) begin
			r = 32767;
		end
		if (r < -32768) begin
			r = -32768;
		end
		plane_q.push_back('{KIND_CORRECT, STATUS_OK, plane_cx[idx], plane_cy[idx],
			plane_c0[idx], r[VEL_W-1:0]});
	endfunction

	initial begin
		errors = 0;
		pending = 0;
	end

	always @(posedge clk or negedge arst_n) begin
		res_t got;
		res_t want;
		if (!arst_n) begin
			threshold = '0;
			ref_frame = '0;
			acc = '0;
			any_fitted = 0;
			plane_q.delete();
		end else begin
			if (cfg_wr_en) begin
				case (cfg_index)
					CFG_THRESHOLD: threshold = cfg_data;
					CFG_REF_FRAME: ref_frame = cfg_data[FRAME_W-1:0];
					default: ;
				endcase
			end
			if (smp.valid && smp.ready) begin
				if (smp.req_type == KIND_CORRECT) begin
					correct_velocity(smp.slice, smp.component, smp.pos_x, smp.pos_y,
						smp.velocity);
				end else begin
					fit_pixel(smp.slice, smp.component, smp.frame, smp.pos_x, smp.pos_y,
						smp.tissue_level, smp.velocity, smp.last);
				end
			end
			if (res.valid && res.ready) begin
				got = '{res.result_kind, res.status, res.coef_x, res.coef_y,
					res.coef_offset, res.corrected_velocity};
				if (plane_q.size() == 0) begin
					errors++;
					$display("%0t unexpected result: kind %0d status %0d", $realtime,
						got.result_kind, got.status);
				end else begin
					want = plane_q.pop_front();
					if (got !== want) begin
						errors++;
						$display("%0t mismatch exp kind %0d st %0d cx %0d cy %0d c0 %0d v %0d",
							$realtime, want.result_kind, want.status, $signed(want.coef_x),
							$signed(want.coef_y), $signed(want.coef_offset),
							$signed(want.corrected_velocity));
						$display("%0t          got kind %0d st %0d cx %0d cy %0d c0 %0d v %0d",
							$realtime, got.result_kind, got.status, $signed(got.coef_x),
							$signed(got.coef_y), $signed(got.coef_offset),
							$signed(got.corrected_velocity));
					end
				end
			end
		end
		pending = plane_q.size();
	end

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Drives fit sequences and correct transactions into the plane fit block over
// several threshold and reference frame settings, with bursty input, random
// output stalls and one long output hold-off; the checker does the scoring.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
	import mpfoc_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int IDLE_LIMIT = 20000;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_wr_en;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	int                    errors;
	int                    pending;

	mpfoc_sample_if smp ();
	mpfoc_result_if res ();

	masked_plane_fit_offset_correction uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.sample    (smp),
		.result    (res)
	);

	mpfoc_checker u_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.smp       (smp),
		.res       (res),
		.errors    (errors),
		.pending   (pending)
	);

	logic [TISSUE_W-1:0] cur_thr;
	logic [FRAME_W-1:0]  cur_ref;
	int                  fitted_idx [$];
	int                  burst_left;
	int                  sent;
	bit                  hold_go;
	int                  hold_cnt;
	int                  rx_mode;
	int                  rx_cyc;
	int                  idle_cycles;

	initial begin
		clk = 0;
	end
	always #4 clk = ~clk;

	// receiver: random stall patterns, plus a long hold on request
	always @(negedge clk) begin
		rx_cyc++;
		if (rx_cyc % 256 == 0) begin
			rx_mode = $urandom_range(0, 3);
		end
		if (hold_go) begin
			hold_go = 0;
			hold_cnt = 400;
		end
		if (hold_cnt > 0) begin
			hold_cnt--;
			res.ready <= 1'b0;
		end else begin
			case (rx_mode)
				0: res.ready <= 1'b1;
				1: res.ready <= $urandom_range(0, 3) != 0;
				2: res.ready <= $urandom_range(0, 1);
				default: res.ready <= (rx_cyc % 7) < 5;
			endcase
		end
	end

	// end the run when nothing moves for too long
	always @(posedge clk) begin
		if ((smp.valid && smp.ready) || (res.valid && res.ready)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
		end
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("tb_top NOT OK");
			$finish;
		end
	end

	task automatic send(input logic rq, input logic [SLICE_W-1:0] sl,
			input logic [COMP_W-1:0] cp, input logic [FRAME_W-1:0] fr,
			input logic [POS_W-1:0] x, input logic [POS_W-1:0] y,
			input logic [TISSUE_W-1:0] ts, input logic [VEL_W-1:0] v, input logic lst);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			if ($urandom_range(0, 3) != 0) begin
				smp.valid <= 1'b0;
				repeat ($urandom_range(1, 12)) @(negedge clk);
			end
		end
		burst_left--;
		smp.valid        <= 1'b1;
		smp.req_type     <= rq;
		smp.slice        <= sl;
		smp.component    <= cp;
		smp.frame        <= fr;
		smp.pos_x        <= x;
		smp.pos_y        <= y;
		smp.tissue_level <= ts;
		smp.velocity     <= v;
		smp.last         <= lst;
		do @(posedge clk); while (!smp.ready);
		@(negedge clk);
		sent++;
	endtask

	task automatic drain();
		smp.valid <= 1'b0;
		wait (pending == 0);
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		drain();
		repeat (20) @(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		@(negedge clk);
		if (idx == CFG_THRESHOLD) begin
			cur_thr = val;
		end else begin
			cur_ref = val[FRAME_W-1:0];
		end
	endtask

	task automatic note_fit(input int sl, input int cp);
		if (cp < COMPONENTS) begin
			fitted_idx.push_back(sl * COMPONENTS + cp);
		end
	endtask

	// one fit: mostly qualifying pixels, on a noisy plane or random, ends with last
	task automatic fit_sequence(input int sl, input int cp, input int npix);
		int ax;
		int ay;
		int c0;
		int val;
		int x;
		int y;
		bit planar;
		logic [FRAME_W-1:0]  fr;
		logic [TISSUE_W-1:0] ts;
		ax = int'($urandom_range(0, 240)) - 120;
		ay = int'($urandom_range(0, 240)) - 120;
		c0 = int'($urandom_range(0, 40000)) - 20000;
		planar = $urandom_range(0, 3) != 0;
		for (int i = 0; i < npix; i++) begin
			x = $urandom_range(0, 255);
			y = $urandom_range(0, 255);
			fr = cur_ref;
			ts = $urandom_range(0, cur_thr);
			if ($urandom_range(0, 6) == 0) begin
				fr = $urandom;
			end
			if ($urandom_range(0, 6) == 0) begin
				ts = $urandom;
			end
			if (planar) begin
				val = ax * x + ay * y + c0 + int'($urandom_range(0, 64)) - 32;
				val = val > 32767 ? 32767 : (val < -32768 ? -32768 : val);
			end else begin
				val = $urandom;
			end
			send(KIND_FIT, sl, cp, fr, x, y, ts, val[15:0], i == npix - 1);
		end
		note_fit(sl, cp);
	endtask

	task automatic random_correct();
		int idx;
		int sl;
		int cp;
		sl = $urandom_range(0, 63);
		cp = $urandom_range(0, 2);
		if (fitted_idx.size() != 0) begin
			idx = fitted_idx[$urandom_range(0, fitted_idx.size() - 1)];
			sl = idx / COMPONENTS;
			cp = idx % COMPONENTS;
		end
		send(KIND_CORRECT, sl, cp, $urandom, $urandom, $urandom, $urandom, $urandom,
			$urandom);
	endtask

	task automatic directed();
		send(KIND_CORRECT, 63, 2, 0, 255, 255, 0, 16'h8000, 1);
		send(KIND_CORRECT, 0, 0, 63, 0, 0, 16'hFFFF, 16'h7FFF, 0);
		// nothing qualifies: singular, zeros stored
		send(KIND_FIT, 0, 0, 1, 10, 10, 0, 100, 1);
		note_fit(0, 0);
		// clean plane on extreme coordinates, one excluded pixel in between
		send(KIND_FIT, 63, 2, 0, 0, 0, 0, 16'h8000, 0);
		send(KIND_FIT, 63, 2, 0, 128, 128, 16'hFFFF, 16'h1234, 0);
		send(KIND_FIT, 63, 2, 0, 255, 0, 0, 16'h7FFF, 0);
		send(KIND_FIT, 63, 2, 0, 0, 255, 0, 0, 1);
		note_fit(63, 2);
		// steep slope: coefficient saturates
		send(KIND_FIT, 1, 1, 0, 0, 0, 0, 16'h8000, 0);
		send(KIND_FIT, 1, 1, 0, 1, 0, 0, 16'h7FFF, 0);
		send(KIND_FIT, 1, 1, 0, 0, 1, 0, 16'h8000, 1);
		note_fit(1, 1);
		// collinear pixels: singular
		send(KIND_FIT, 2, 0, 0, 1, 1, 0, 5, 0);
		send(KIND_FIT, 2, 0, 0, 2, 2, 0, 9, 0);
		send(KIND_FIT, 2, 0, 0, 3, 3, 0, 13, 1);
		note_fit(2, 0);
		// component out of range: emitted, not stored
		send(KIND_FIT, 5, 3, 0, 0, 0, 0, 1, 0);
		send(KIND_FIT, 5, 3, 0, 9, 0, 0, 2, 0);
		send(KIND_FIT, 5, 3, 0, 0, 9, 0, 3, 1);
		send(KIND_CORRECT, 63, 2, 0, 0, 0, 0, 16'h7FFF, 0);
		send(KIND_CORRECT, 63, 2, 0, 255, 255, 0, 16'h8000, 1);
		send(KIND_CORRECT, 1, 1, 0, 255, 255, 0, 16'h7FFF, 0);
		send(KIND_CORRECT, 1, 1, 0, 255, 0, 0, 16'h8000, 0);
		send(KIND_CORRECT, 5, 3, 0, 1, 1, 0, 16'h4321, 0);
		send(KIND_CORRECT, 0, 0, 0, 7, 7, 0, 16'hFFFF, 0);
	endtask

	initial begin
		int r;
		int goal;
		bit held;
		arst_n = 0;
		cfg_wr_en = 0;
		cfg_index = '0;
		cfg_data = '0;
		smp.valid = 0;
		smp.req_type = 0;
		smp.slice = '0;
		smp.component = '0;
		smp.frame = '0;
		smp.pos_x = '0;
		smp.pos_y = '0;
		smp.tissue_level = '0;
		smp.velocity = '0;
		smp.last = 0;
		res.ready = 1;
		cur_thr = '0;
		cur_ref = '0;
		burst_left = 0;
		sent = 0;
		hold_go = 0;
		hold_cnt = 0;
		rx_mode = 0;
		rx_cyc = 0;
		idle_cycles = 0;
		held = 0;
		repeat (12) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		directed();

		for (int ph = 0; ph < 8; ph++) begin
			case (ph)
				0: begin write_reg(CFG_THRESHOLD, 16'hFFFF); write_reg(CFG_REF_FRAME, 63); end
				1: begin write_reg(CFG_THRESHOLD, 0); write_reg(CFG_REF_FRAME, 0); end
				default: begin
					write_reg(CFG_THRESHOLD, $urandom);
					write_reg(CFG_REF_FRAME, $urandom_range(0, 63));
				end
			endcase
			goal = sent + 170;
			while (sent < goal) begin
				r = $urandom_range(0, 99);
				if (ph == 2 && !held && goal - sent <= 100) begin
					// hold the output while the sender keeps pushing
					held = 1;
					hold_go = 1;
					repeat (40) random_correct();
				end else if (r < 45) begin
					fit_sequence($urandom_range(0, 63),
						$urandom_range(0, 19) == 0 ? 3 : $urandom_range(0, 2),
						$urandom_range(0, 19) == 0 ? $urandom_range(60, 120)
							: $urandom_range(1, 24));
				end else if (r < 90) begin
					random_correct();
				end else if (r < 95) begin
					send(KIND_CORRECT, $urandom, 3, $urandom, $urandom, $urandom, $urandom,
						$urandom, $urandom);
				end else begin
					drain();
				end
			end
			fit_sequence($urandom_range(0, 63), $urandom_range(0, 2), 3);
		end

		drain();
		repeat (100) @(posedge clk);
		if (errors == 0 && pending == 0) begin
			$display("tb_top OK");
		end else begin
			$display("tb_top NOT OK");
		end
		$finish;
	end

endmodule

`default_nettype wire

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/mpfoc_pkg.sv
hw/rtl/mpfoc_sample_if.sv
hw/rtl/mpfoc_result_if.sv
hw/rtl/mpfoc_front.sv
hw/rtl/mpfoc_queue.sv
hw/rtl/mpfoc_solver.sv
hw/rtl/mpfoc_back.sv
hw/rtl/masked_plane_fit_offset_correction.sv
tb/mpfoc_checker.sv
tb/tb_top.sv
